// ----- rtl/capture_file_record_deframer_defines.svh -----
// assertion macros for the capture file record deframer
// used by the top level only, no other dependencies
`ifndef CAPTURE_FILE_RECORD_DEFRAMER_DEFINES_SVH
`define CAPTURE_FILE_RECORD_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CFRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfrd check failed");

// next-cycle implication, disabled while reset is asserted
`define CFRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfrd check failed");

`endif

// ----- rtl/cfrd_pkg.sv -----
// shared types and constants of the capture file record deframer
// no dependencies; used by cfrd_stamp and the top level
`default_nettype none

package cfrd_pkg;

    // magic numbers, read little-endian from the first four file bytes
    localparam logic [31:0] MAGIC_US     = 32'hA1B2C3D4;
    localparam logic [31:0] MAGIC_NS     = 32'hA1B23C4D;
    localparam logic [31:0] MAGIC_US_REV = 32'hD4C3B2A1;
    localparam logic [31:0] MAGIC_NS_REV = 32'h4D3CB2A1;
    localparam logic [31:0] MAGIC_NG     = 32'h0A0D0D0A;

    localparam logic [31:0] LINK_MASK     = 32'h03FFFFFF;
    localparam logic [31:0] LINK_ETHERNET = 32'd1;
    localparam logic [15:0] HDR_MAJOR_VER = 16'd2;
    localparam logic [15:0] HDR_MINOR_VER = 16'd4;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [9:0]  NS_PER_US  = 10'd1000;

    localparam int TS_W   = 62;
    localparam int CAP_W  = 19;
    localparam int WORD_W = 32;

    // register index of max_capture_length, byte address 4 * index
    localparam logic REG_MAX_CAP = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // status codes
    localparam logic [3:0] ST_EOF         = 4'd0;
    localparam logic [3:0] ST_SHORT_HDR   = 4'd1;
    localparam logic [3:0] ST_BAD_MAGIC   = 4'd2;
    localparam logic [3:0] ST_PCAPNG      = 4'd3;
    localparam logic [3:0] ST_BAD_VERSION = 4'd4;
    localparam logic [3:0] ST_BAD_LINK    = 4'd5;
    localparam logic [3:0] ST_TRUNC_HDR   = 4'd6;
    localparam logic [3:0] ST_TRUNC_DATA  = 4'd7;
    localparam logic [3:0] ST_BAD_CAPLEN  = 4'd8;
    localparam logic [3:0] ST_NONE        = 4'd15;

    // input operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // operands handed to the timestamp unit
    typedef struct packed {
        logic [WORD_W-1:0] seconds;
        logic [WORD_W-1:0] fraction;
        logic              nanosecond;
    } stamp_in_t;

endpackage

`default_nettype wire

// ----- rtl/capture_file_record_deframer.sv -----
// capture file record deframer, top level
// depends on cfrd_pkg, cfrd_stamp and capture_file_record_deframer_defines.svh
//
// usage
//   s_axis: one item per file byte; tuser = operation (0 byte, 1 end of input),
//     tdata = the file byte. end of input reports eof or the kind of truncation
//   m_axis: one result per record header, payload byte or status report;
//     tuser = result kind, tlast marks the final payload byte of a record
//     (or a header with zero captured length)
//   apb: register 0 at address 0 holds max_capture_length (19 bits)
//   path: an accepted byte waits in the input register, then the processing
//     stage loads any result it gives into the result register
//   throughput: one byte per clock while m_axis_tready stays high; every
//     byte passes one registered step, and the timestamp products are formed
//     from the stored seconds and fraction bytes while the rest of the record
//     header streams in, so only a 62-bit add sits on the final byte
//   reset: synchronous, active low; the block waits for a new global header,
//     max_capture_length returns to 262144, no clearing pass is needed
//   stall: with m_axis_tready low the result register holds, one more byte
//     waits in the input register, then s_axis_tready drops
//   errors are sticky: later bytes are dropped, each end of input repeats
//     the stored status
`default_nettype none

`include "capture_file_record_deframer_defines.svh"

module capture_file_record_deframer #(
    parameter int unsigned MAX_CAP_RESET = 262144
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tuser,   // [0] operation
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata,   // [61:0] timestamp_ns, [80:62] captured_length,
                                              // [112:81] wire_length, [144:113] record_number,
                                              // [152:145] payload_byte, [156:153] status
    output logic [1:0]        m_axis_tuser,   // [1:0] result_kind
    output logic              m_axis_tlast,   // last_of_record
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CAP_W  = cfrd_pkg::CAP_W;
    localparam int WORD_W = cfrd_pkg::WORD_W;
    localparam int TS_W   = cfrd_pkg::TS_W;

    typedef enum logic [1:0] {
        PH_GLOBAL,
        PH_RECHDR,
        PH_PAYLOAD,
        PH_STOPPED
    } phase_t;

    // combine four stored bytes in file byte order
    function automatic logic [31:0] word32(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic big);
        if (big) begin
            return {b0, b1, b2, b3};
        end
        return {b3, b2, b1, b0};
    endfunction

    function automatic logic [15:0] word16(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic big);
        return big ? {b0, b1} : {b1, b0};
    endfunction

    // input register
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;

    // block state
    phase_t             phase_reg, phase_next;
    logic [7:0]         hb_reg  [16];
    logic [7:0]         hb_next [16];
    logic [4:0]         pos_reg, pos_next;
    logic [CAP_W-1:0]   rem_reg, rem_next;
    logic               big_reg, big_next;
    logic               nsec_reg, nsec_next;
    logic [3:0]         sticky_reg, sticky_next;
    logic [WORD_W-1:0]  records_reg, records_next;
    logic [CAP_W-1:0]   max_cap_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;
    logic [159:0]       out_data_reg, out_data_next;

    logic               out_free;
    logic               proceed;
    logic               cfg_write;

    cfrd_pkg::stamp_in_t stamp_in;
    logic [TS_W-1:0]     stamp_ns;

    // field views of the header store
    logic [WORD_W-1:0]  rec_cap;
    logic [WORD_W-1:0]  rec_wire;
    logic [WORD_W-1:0]  magic;
    logic [15:0]        ver_major;
    logic [15:0]        ver_minor;
    logic [WORD_W-1:0]  link_word;
    logic [3:0]         gh_slot;

    // handshakes: the processing stage advances when the result register has room
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proceed       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == cfrd_pkg::REG_MAX_CAP);
    assign prdata    = (paddr[2] == cfrd_pkg::REG_MAX_CAP) ? 32'(max_cap_reg) : 32'd0;

    // seconds and fraction come from stored bytes, settled well before the last header byte
    assign stamp_in.seconds    = word32(hb_reg[0], hb_reg[1], hb_reg[2], hb_reg[3], big_reg);
    assign stamp_in.fraction   = word32(hb_reg[4], hb_reg[5], hb_reg[6], hb_reg[7], big_reg);
    assign stamp_in.nanosecond = nsec_reg;

    cfrd_stamp u_stamp (
        .aclk         (aclk),
        .stamp_in     (stamp_in),
        .timestamp_ns (stamp_ns)
    );

    // the current byte stands in for the last slot of a header
    assign rec_cap   = word32(hb_reg[8], hb_reg[9], hb_reg[10], hb_reg[11], big_reg);
    assign rec_wire  = word32(hb_reg[12], hb_reg[13], hb_reg[14], in_byte_reg, big_reg);
    assign magic     = {in_byte_reg, hb_reg[2], hb_reg[1], hb_reg[0]};
    assign ver_major = word16(hb_reg[4], hb_reg[5], big_reg);
    assign ver_minor = word16(hb_reg[6], hb_reg[7], big_reg);
    assign link_word = rec_wire;
    // global header bytes 16..23 land in slots 8..15
    assign gh_slot   = pos_reg[4] ? {1'b1, pos_reg[2:0]} : pos_reg[3:0];

    always_comb begin
        phase_next     = phase_reg;
        hb_next        = hb_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        big_next       = big_reg;
        nsec_next      = nsec_reg;
        sticky_next    = sticky_reg;
        records_next   = records_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;

        if (proceed) begin
            if (in_op_reg == cfrd_pkg::OP_END) begin
                // end of input: status depends on where the stream stopped
                unique case (phase_reg)
                    PH_STOPPED: sticky_next = sticky_reg;
                    PH_GLOBAL:  sticky_next = cfrd_pkg::ST_SHORT_HDR;
                    PH_RECHDR:  sticky_next = (pos_reg == 5'd0) ? cfrd_pkg::ST_EOF
                                                                : cfrd_pkg::ST_TRUNC_HDR;
                    PH_PAYLOAD: sticky_next = cfrd_pkg::ST_TRUNC_DATA;
                    default:    sticky_next = sticky_reg;
                endcase
                phase_next = PH_STOPPED;
            end else begin
                unique case (phase_reg)
                    PH_GLOBAL: begin
                        hb_next[gh_slot] = in_byte_reg;
                        pos_next         = pos_reg + 5'd1;
                        if (pos_reg == 5'd3) begin
                            if (magic == cfrd_pkg::MAGIC_US) begin
                                big_next  = 1'b0;
                                nsec_next = 1'b0;
                            end else if (magic == cfrd_pkg::MAGIC_NS) begin
                                big_next  = 1'b0;
                                nsec_next = 1'b1;
                            end else if (magic == cfrd_pkg::MAGIC_US_REV) begin
                                big_next  = 1'b1;
                                nsec_next = 1'b0;
                            end else if (magic == cfrd_pkg::MAGIC_NS_REV) begin
                                big_next  = 1'b1;
                                nsec_next = 1'b1;
                            end else if (magic == cfrd_pkg::MAGIC_NG) begin
                                sticky_next = cfrd_pkg::ST_PCAPNG;
                                phase_next  = PH_STOPPED;
                            end else begin
                                sticky_next = cfrd_pkg::ST_BAD_MAGIC;
                                phase_next  = PH_STOPPED;
                            end
                        end else if (pos_reg == 5'd23) begin
                            pos_next = 5'd0;
                            if (ver_major != cfrd_pkg::HDR_MAJOR_VER ||
                                ver_minor != cfrd_pkg::HDR_MINOR_VER) begin
                                sticky_next = cfrd_pkg::ST_BAD_VERSION;
                                phase_next  = PH_STOPPED;
                            end else if ((link_word & cfrd_pkg::LINK_MASK) !=
                                         cfrd_pkg::LINK_ETHERNET) begin
                                sticky_next = cfrd_pkg::ST_BAD_LINK;
                                phase_next  = PH_STOPPED;
                            end else begin
                                phase_next = PH_RECHDR;
                            end
                        end
                    end
                    PH_RECHDR: begin
                        hb_next[pos_reg[3:0]] = in_byte_reg;
                        pos_next              = pos_reg + 5'd1;
                        if (pos_reg == 5'd15) begin
                            pos_next = 5'd0;
                            if (rec_cap > WORD_W'(max_cap_reg)) begin
                                sticky_next = cfrd_pkg::ST_BAD_CAPLEN;
                                phase_next  = PH_STOPPED;
                            end else begin
                                out_valid_next        = 1'b1;
                                out_kind_next         = cfrd_pkg::KIND_HEADER;
                                out_data_next         = '0;
                                out_data_next[61:0]   = stamp_ns;
                                out_data_next[80:62]  = rec_cap[CAP_W-1:0];
                                out_data_next[112:81] = rec_wire;
                                out_data_next[144:113] = records_reg;
                                if (rec_cap == '0) begin
                                    out_last_next = 1'b1;
                                    records_next  = records_reg + 32'd1;
                                end else begin
                                    out_last_next = 1'b0;
                                    rem_next      = rec_cap[CAP_W-1:0];
                                    phase_next    = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        out_valid_next          = 1'b1;
                        out_kind_next           = cfrd_pkg::KIND_PAYLOAD;
                        out_data_next           = '0;
                        out_data_next[144:113]  = records_reg;
                        out_data_next[152:145]  = in_byte_reg;
                        rem_next                = (rem_reg != '0) ? rem_reg - CAP_W'(1) : rem_reg;
                        out_last_next           = (rem_next == '0);
                        if (rem_next == '0) begin
                            records_next = records_reg + 32'd1;
                            phase_next   = PH_RECHDR;
                        end
                    end
                    PH_STOPPED: begin
                        // bytes after an error are dropped
                    end
                    default: begin
                    end
                endcase
            end

            // every status report, new or repeated, comes out here
            if (phase_next == PH_STOPPED && (in_op_reg == cfrd_pkg::OP_END ||
                                             phase_reg != PH_STOPPED)) begin
                out_valid_next          = 1'b1;
                out_kind_next           = cfrd_pkg::KIND_STATUS;
                out_last_next           = 1'b0;
                out_data_next           = '0;
                out_data_next[144:113]  = records_reg;
                out_data_next[156:153]  = sticky_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_GLOBAL;
            pos_reg       <= 5'd0;
            rem_reg       <= '0;
            big_reg       <= 1'b0;
            nsec_reg      <= 1'b0;
            sticky_reg    <= cfrd_pkg::ST_NONE;
            records_reg   <= '0;
            max_cap_reg   <= CAP_W'(MAX_CAP_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proceed) begin
                in_valid_reg <= 1'b0;
            end
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            big_reg       <= big_next;
            nsec_reg      <= nsec_next;
            sticky_reg    <= sticky_next;
            records_reg   <= records_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write) begin
                max_cap_reg <= pwdata[CAP_W-1:0];
            end
        end
        // payload registers
        if (s_axis_tvalid && s_axis_tready) begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        hb_reg       <= hb_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = out_data_reg;

    // a stopped block never restarts without reset
    `CFRD_ASSERT_NEXT(a_stop_holds, aclk, aresetn, phase_reg == PH_STOPPED, phase_reg == PH_STOPPED)
    // end of input always stops the block
    `CFRD_ASSERT_NEXT(a_end_stops, aclk, aresetn, proceed && in_op_reg == cfrd_pkg::OP_END, phase_reg == PH_STOPPED && out_valid_reg && out_kind_reg == cfrd_pkg::KIND_STATUS)
    // payload phase always has bytes left to take
    `CFRD_ASSERT_NOW(a_payload_left, aclk, aresetn, phase_reg == PH_PAYLOAD, rem_reg != '0)
    // record header position stays inside the sixteen-byte header
    `CFRD_ASSERT_NOW(a_rechdr_pos, aclk, aresetn, phase_reg == PH_RECHDR, pos_reg[4] == 1'b0)

endmodule

`default_nettype wire

// ----- rtl/cfrd_stamp.sv -----
// timestamp unit: seconds * 1e9 plus fraction scaled to nanoseconds
// depends on cfrd_pkg; products are registered, the sum is combinational
`default_nettype none

module cfrd_stamp (
    input  wire logic                     aclk,
    input  wire cfrd_pkg::stamp_in_t      stamp_in,
    output logic [cfrd_pkg::TS_W-1:0]     timestamp_ns
);

    localparam int FRAC_W = cfrd_pkg::WORD_W + 10;

    logic [cfrd_pkg::TS_W-1:0] sec_ns_reg;
    logic [cfrd_pkg::TS_W-1:0] sec_ns_next;
    logic [FRAC_W-1:0]         frac_ns_reg;
    logic [FRAC_W-1:0]         frac_ns_next;

    // 32 x 30 constant product fits 62 bits
    always_comb begin
        sec_ns_next = cfrd_pkg::TS_W'(stamp_in.seconds) *
                      cfrd_pkg::TS_W'(cfrd_pkg::NS_PER_SEC);
        if (stamp_in.nanosecond) begin
            frac_ns_next = FRAC_W'(stamp_in.fraction);
        end else begin
            frac_ns_next = FRAC_W'(stamp_in.fraction) * FRAC_W'(cfrd_pkg::NS_PER_US);
        end
    end

    always_ff @(posedge aclk) begin
        sec_ns_reg  <= sec_ns_next;
        frac_ns_reg <= frac_ns_next;
    end

    // wraps modulo 2^62
    assign timestamp_ns = sec_ns_reg + cfrd_pkg::TS_W'(frac_ns_reg);

endmodule

`default_nettype wire

// ----- tb/tb_capture_file_record_deframer.sv -----
// self-checking testbench for the capture file record deframer
// feeds whole capture files byte by byte, predicts every result and checks it
// depends on cfrd_pkg and the capture_file_record_deframer top level
`default_nettype none

module tb_capture_file_record_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned MAX_CAP_TOP  = 262144;
    localparam int unsigned LATENCY_PAD  = 8;       // a result passes the input and result registers after its item
    localparam longint unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_BYTES  = 300;     // file bytes per register setting
    localparam int unsigned QUIET_BYTES  = 300;     // payload of the record sent with no idling
    localparam int unsigned TAIL_SHORT   = 24;      // stray items after a file that got past its global header
    localparam int unsigned TAIL_LONG    = 1950;    // stray items after an early header error
    localparam logic [2:0]  MAX_CAP_ADDR = {cfrd_pkg::REG_MAX_CAP, 2'b00};

    // where the parser stands inside the file
    typedef enum logic [1:0] {
        FILE_HDR,
        REC_HDR,
        PAYLOAD_BYTES,
        HALTED
    } parse_phase_t;

    // how this run's file ends; the last five stop inside the global header
    typedef enum int unsigned {
        END_EOF,
        END_TRUNC_HDR,
        END_TRUNC_DATA,
        END_BAD_CAPLEN,
        END_SHORT_HDR,
        END_BAD_MAGIC,
        END_PCAPNG,
        END_BAD_VERSION,
        END_BAD_LINK
    } file_ending_t;

    // one result item, field by field
    typedef struct {
        logic [1:0]  kind;
        logic [61:0] stamp;
        logic [18:0] cap_len;
        logic [31:0] wire_len;
        logic [31:0] rec_no;
        logic [7:0]  pkt_byte;
        logic        last;
        logic [3:0]  status;
    } deframer_result_t;

    // parses the same byte stream as the block and keeps the results it must give
    class deframer_scoreboard;
        parse_phase_t     phase;
        logic [7:0]       hdr [16];
        int unsigned      pos;
        logic [18:0]      left;
        bit               big_end;
        bit               nano;
        logic [3:0]       sticky;
        logic [31:0]      recs;
        logic [18:0]      max_cap;
        deframer_result_t results_due [$];
        int unsigned      mismatches;
        int unsigned      n_headers;
        int unsigned      n_payload;
        int unsigned      n_status;

        function new();
            phase = FILE_HDR;
            foreach (hdr[i]) hdr[i] = '0;
            pos = 0;
            left = '0;
            big_end = 0;
            nano = 0;
            sticky = cfrd_pkg::ST_NONE;
            recs = '0;
            max_cap = 19'(MAX_CAP_TOP);
            mismatches = 0;
            n_headers = 0;
            n_payload = 0;
            n_status = 0;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        function logic [31:0] word_at(int unsigned at);
            if (big_end) begin
                return {hdr[at], hdr[at+1], hdr[at+2], hdr[at+3]};
            end
            return {hdr[at+3], hdr[at+2], hdr[at+1], hdr[at]};
        endfunction

        function logic [15:0] half_at(int unsigned at);
            return big_end ? {hdr[at], hdr[at+1]} : {hdr[at+1], hdr[at]};
        endfunction

        // status report; the code sticks and the parser stops
        function void halt_with(logic [3:0] code);
            deframer_result_t r;
            r = '{default: '0};
            sticky = code;
            phase = HALTED;
            r.kind = cfrd_pkg::KIND_STATUS;
            r.rec_no = recs;
            r.status = code;
            results_due.push_back(r);
        endfunction

        // one accepted input item
        function void note_item(logic op, logic [7:0] b);
            deframer_result_t r;
            logic [31:0]      magic, sec, frac, cap32, wire_w;
            longint unsigned  stamp64;
            int unsigned      slot;
            r = '{default: '0};
            if (op == cfrd_pkg::OP_END) begin
                case (phase)
                    HALTED:   halt_with(sticky);
                    FILE_HDR: halt_with(cfrd_pkg::ST_SHORT_HDR);
                    REC_HDR:  halt_with(pos == 0 ? cfrd_pkg::ST_EOF : cfrd_pkg::ST_TRUNC_HDR);
                    default:  halt_with(cfrd_pkg::ST_TRUNC_DATA);
                endcase
                return;
            end
            case (phase)
                FILE_HDR: begin
                    // bytes 16..23 land over thiszone and sigfigs
                    slot = (pos < 16) ? pos : pos - 8;
                    hdr[slot] = b;
                    pos++;
                    if (pos == 4) begin
                        magic = {hdr[3], hdr[2], hdr[1], hdr[0]};
                        if (magic == cfrd_pkg::MAGIC_US) begin
                            big_end = 0;
                            nano = 0;
                        end else if (magic == cfrd_pkg::MAGIC_NS) begin
                            big_end = 0;
                            nano = 1;
                        end else if (magic == cfrd_pkg::MAGIC_US_REV) begin
                            big_end = 1;
                            nano = 0;
                        end else if (magic == cfrd_pkg::MAGIC_NS_REV) begin
                            big_end = 1;
                            nano = 1;
                        end else if (magic == cfrd_pkg::MAGIC_NG) begin
                            halt_with(cfrd_pkg::ST_PCAPNG);
                        end else begin
                            halt_with(cfrd_pkg::ST_BAD_MAGIC);
                        end
                    end else if (pos >= 24) begin
                        pos = 0;
                        if (half_at(4) != cfrd_pkg::HDR_MAJOR_VER ||
                            half_at(6) != cfrd_pkg::HDR_MINOR_VER) begin
                            halt_with(cfrd_pkg::ST_BAD_VERSION);
                        end else if ((word_at(12) & cfrd_pkg::LINK_MASK) !=
                                     cfrd_pkg::LINK_ETHERNET) begin
                            halt_with(cfrd_pkg::ST_BAD_LINK);
                        end else begin
                            phase = REC_HDR;
                        end
                    end
                end
                REC_HDR: begin
                    hdr[pos] = b;
                    pos++;
                    if (pos == 16) begin
                        pos = 0;
                        sec = word_at(0);
                        frac = word_at(4);
                        cap32 = word_at(8);
                        wire_w = word_at(12);
                        if (cap32 > 32'(max_cap)) begin
                            halt_with(cfrd_pkg::ST_BAD_CAPLEN);
                        end else begin
                            // out-of-range fractions are scaled as they are
                            stamp64 = 64'(sec) * 64'd1000000000
                                    + (nano ? 64'(frac) : 64'(frac) * 64'd1000);
                            r.kind = cfrd_pkg::KIND_HEADER;
                            r.stamp = stamp64[61:0];
                            r.cap_len = cap32[18:0];
                            r.wire_len = wire_w;
                            r.rec_no = recs;
                            if (cap32 == 0) begin
                                r.last = 1'b1;
                                recs++;
                            end else begin
                                left = cap32[18:0];
                                phase = PAYLOAD_BYTES;
                            end
                            results_due.push_back(r);
                        end
                    end
                end
                PAYLOAD_BYTES: begin
                    r.kind = cfrd_pkg::KIND_PAYLOAD;
                    r.rec_no = recs;
                    r.pkt_byte = b;
                    if (left > 0) left--;
                    if (left == 0) begin
                        r.last = 1'b1;
                        recs++;
                        phase = REC_HDR;
                    end
                    results_due.push_back(r);
                end
                default: ;  // stopped: the byte is dropped
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        // one accepted result item against the oldest one due
        function void check_result(deframer_result_t got);
            deframer_result_t want;
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                         $time, got.kind, got.status);
                return;
            end
            want = results_due.pop_front();
            case (want.kind)
                cfrd_pkg::KIND_HEADER:  n_headers++;
                cfrd_pkg::KIND_PAYLOAD: n_payload++;
                default:                n_status++;
            endcase
            compare_field("result_kind", 64'(want.kind), 64'(got.kind));
            compare_field("timestamp_ns", 64'(want.stamp), 64'(got.stamp));
            compare_field("captured_length", 64'(want.cap_len), 64'(got.cap_len));
            compare_field("wire_length", 64'(want.wire_len), 64'(got.wire_len));
            compare_field("record_number", 64'(want.rec_no), 64'(got.rec_no));
            compare_field("payload_byte", 64'(want.pkt_byte), 64'(got.pkt_byte));
            compare_field("last_of_record", 64'(want.last), 64'(got.last));
            compare_field("status", 64'(want.status), 64'(got.status));
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    deframer_scoreboard sb;
    deframer_result_t   got_item;
    bit                 quiet = 1'b0;       // no idling on either side while set
    longint unsigned    cycle_count = 0;
    int unsigned        items_sent = 0;
    logic [7:0]         byte_q [$];         // file bytes built but not yet sent
    bit                 file_big;
    bit                 file_nano;
    file_ending_t       ending;
    int unsigned        cap_limits [5];

    capture_file_record_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // run limit, far above the slowest correct run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, sb.pending());
            $display("tb_capture_file_record_deframer: FAIL");
            $finish;
        end
    end

    // result side: check each accepted item, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_item.kind = m_axis_tuser;
            got_item.stamp = m_axis_tdata[61:0];
            got_item.cap_len = m_axis_tdata[80:62];
            got_item.wire_len = m_axis_tdata[112:81];
            got_item.rec_no = m_axis_tdata[144:113];
            got_item.pkt_byte = m_axis_tdata[152:145];
            got_item.status = m_axis_tdata[156:153];
            got_item.last = m_axis_tlast;
            sb.check_result(got_item);
        end
        m_axis_tready <= quiet || ($urandom_range(99) >= 32);
    end

    // one input item; idles at random first, returns at the accepting edge
    // with tvalid still high so the next item can follow without a gap
    task automatic send_item(logic op, logic [7:0] b);
        while (!quiet && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_item(op, b);
        items_sent++;
    endtask

    task automatic flush_bytes();
        foreach (byte_q[i]) send_item(cfrd_pkg::OP_BYTE, byte_q[i]);
        byte_q.delete();
    endtask

    // sender pauses until every result has come, then lets the pipeline empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    // setup phase, access phase, then an idle phase so accesses never touch
    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // only while the block is idle; the value is read back
    task automatic write_max_cap(int unsigned value);
        logic [31:0] rd;
        apb_access(1'b1, MAX_CAP_ADDR, 32'(value), rd);
        sb.max_cap = 19'(value);
        apb_access(1'b0, MAX_CAP_ADDR, '0, rd);
        sb.compare_field("max_capture_length readback", 64'(value), 64'(rd));
    endtask

    // multi-byte fields in the byte order of this file
    task automatic queue_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) byte_q.push_back(file_big ? w[31 - 8*i -: 8] : w[8*i +: 8]);
    endtask

    task automatic queue_half(logic [15:0] h);
        for (int i = 0; i < 2; i++) byte_q.push_back(file_big ? h[15 - 8*i -: 8] : h[8*i +: 8]);
    endtask

    task automatic queue_file_header(logic [15:0] major, logic [15:0] minor, logic [31:0] link);
        queue_word(file_nano ? cfrd_pkg::MAGIC_NS : cfrd_pkg::MAGIC_US);
        queue_half(major);
        queue_half(minor);
        queue_word($urandom);   // thiszone
        queue_word($urandom);   // sigfigs
        queue_word($urandom);   // snaplen
        queue_word(link);
    endtask

    // record header plus n random payload bytes
    task automatic queue_record(logic [31:0] sec, logic [31:0] frac, logic [31:0] cap,
                                logic [31:0] wire_len, int unsigned n);
        queue_word(sec);
        queue_word(frac);
        queue_word(cap);
        queue_word(wire_len);
        repeat (n) byte_q.push_back(8'($urandom));
    endtask

    task automatic queue_random_record(logic [31:0] cap, int unsigned n);
        logic [31:0] sec, frac, frac_top;
        frac_top = file_nano ? 32'd999999999 : 32'd999999;
        case ($urandom_range(7))
            0:       sec = '0;
            1:       sec = '1;
            default: sec = $urandom;
        endcase
        case ($urandom_range(7))
            0:       frac = '0;
            1:       frac = '1;    // out of range, still scaled
            2:       frac = frac_top;
            default: frac = $urandom_range(frac_top, 0);
        endcase
        queue_record(sec, frac, cap, $urandom_range(1) ? cap : $urandom, n);
    endtask

    // mostly short records, now and then empty, or at the limit when it is at most 64
    function automatic logic [31:0] pick_cap(int unsigned lim);
        case ($urandom_range(9))
            0:       return '0;
            1:       return (lim <= 64) ? lim : $urandom_range(64, 0);
            default: return $urandom_range((lim < 24) ? lim : 24, 0);
        endcase
    endfunction

    // stray bytes and repeated end-of-input after the block has stopped
    task automatic send_tail(int unsigned n);
        for (int i = 0; i < n; i++) begin
            send_item(($urandom_range(4) == 0) ? cfrd_pkg::OP_END : cfrd_pkg::OP_BYTE,
                      8'($urandom));
        end
        send_item(cfrd_pkg::OP_END, 8'($urandom));
    endtask

    initial begin : stimulus
        int unsigned lim, cap, phase_bytes, k;
        logic [31:0] word, rd;
        logic [15:0] major, minor;

        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apb_access(1'b0, MAX_CAP_ADDR, '0, rd);
        sb.compare_field("max_capture_length after reset", 64'(MAX_CAP_TOP), 64'(rd));

        // one file per run, since errors are sticky and reset comes only once:
        // the seed picks byte order, stamp unit and how the file ends
        file_big = $urandom_range(1);
        file_nano = $urandom_range(1);
        if ($urandom_range(3) == 0) begin
            ending = file_ending_t'($urandom_range(END_BAD_LINK, END_SHORT_HDR));
        end else begin
            ending = file_ending_t'($urandom_range(END_BAD_CAPLEN, END_EOF));
        end

        if (ending <= END_BAD_CAPLEN) begin
            // directed: header with all upper link bits set, then a zero-length
            // record, maximum stamp fields and wire length, and the top valid fraction
            queue_file_header(cfrd_pkg::HDR_MAJOR_VER, cfrd_pkg::HDR_MINOR_VER, 32'hFC000001);
            queue_record('0, '0, '0, '0, 0);
            queue_record('1, '1, 32'd1, '1, 1);
            queue_record('1, file_nano ? 32'd999999999 : 32'd999999, 32'd2, 32'd2, 2);
            flush_bytes();
            drain_results();

            // random records under several limits, the extremes among them
            cap_limits = '{MAX_CAP_TOP, 0, 1, 17, $urandom_range(64, 2)};
            foreach (cap_limits[i]) begin
                lim = cap_limits[i];
                write_max_cap(lim);
                phase_bytes = 0;
                while (phase_bytes < PHASE_BYTES) begin
                    cap = pick_cap(lim);
                    queue_random_record(cap, cap);
                    phase_bytes += 16 + cap;
                end
                flush_bytes();
                drain_results();
            end

            // one long record, streamed with no idling at all
            write_max_cap(MAX_CAP_TOP);
            quiet = 1'b1;
            queue_random_record(32'(QUIET_BYTES), QUIET_BYTES);
            flush_bytes();
            drain_results();
            quiet = 1'b0;

            case (ending)
                END_TRUNC_HDR: begin
                    repeat ($urandom_range(15, 1)) byte_q.push_back(8'($urandom));
                end
                END_TRUNC_DATA: begin
                    cap = $urandom_range(40, 1);
                    queue_random_record(cap, $urandom_range(cap - 1, 0));
                end
                END_BAD_CAPLEN: begin
                    lim = $urandom_range(64, 0);
                    write_max_cap(lim);
                    cap = $urandom_range(1) ? lim + 1 : $urandom_range(32'hFFFFFFFF, lim + 1);
                    queue_random_record(cap, 0);
                end
                default: ;  // eof right at a record boundary
            endcase
        end else begin
            write_max_cap($urandom_range(MAX_CAP_TOP, 0));
            case (ending)
                END_SHORT_HDR: begin
                    queue_file_header(cfrd_pkg::HDR_MAJOR_VER, cfrd_pkg::HDR_MINOR_VER,
                                      {6'($urandom), 26'd1});
                    k = $urandom_range(23, 0);
                    while (byte_q.size() > k) void'(byte_q.pop_back());
                end
                END_BAD_MAGIC: begin
                    do begin
                        word = $urandom;
                    end while (word inside {cfrd_pkg::MAGIC_US, cfrd_pkg::MAGIC_NS,
                                            cfrd_pkg::MAGIC_US_REV, cfrd_pkg::MAGIC_NS_REV,
                                            cfrd_pkg::MAGIC_NG});
                    for (int i = 0; i < 4; i++) byte_q.push_back(word[8*i +: 8]);
                    repeat (20) byte_q.push_back(8'($urandom));
                end
                END_PCAPNG: begin
                    word = cfrd_pkg::MAGIC_NG;
                    for (int i = 0; i < 4; i++) byte_q.push_back(word[8*i +: 8]);
                    repeat (20) byte_q.push_back(8'($urandom));
                end
                END_BAD_VERSION: begin
                    // wrong major, wrong minor, or both
                    do begin
                        major = $urandom_range(1) ? cfrd_pkg::HDR_MAJOR_VER : 16'($urandom);
                        minor = $urandom_range(1) ? cfrd_pkg::HDR_MINOR_VER : 16'($urandom);
                    end while (major == cfrd_pkg::HDR_MAJOR_VER &&
                               minor == cfrd_pkg::HDR_MINOR_VER);
                    queue_file_header(major, minor, {6'($urandom), 26'd1});
                end
                default: begin
                    // link type other than ethernet in its low 26 bits
                    do begin
                        word = $urandom_range(1) ? $urandom
                                                 : {6'($urandom), 26'($urandom_range(3, 0))};
                    end while ((word & cfrd_pkg::LINK_MASK) == cfrd_pkg::LINK_ETHERNET);
                    queue_file_header(cfrd_pkg::HDR_MAJOR_VER, cfrd_pkg::HDR_MINOR_VER, word);
                end
            endcase
        end

        flush_bytes();
        send_item(cfrd_pkg::OP_END, 8'($urandom));
        send_tail((ending <= END_BAD_CAPLEN) ? TAIL_SHORT : TAIL_LONG);
        drain_results();

        $display("covered a %s-endian file with %s stamps, %0d items in, ending in status %0d",
                 file_big ? "big" : "little", file_nano ? "ns" : "us", items_sent, sb.sticky);
        $display("checked %0d record headers, %0d payload bytes, %0d status reports",
                 sb.n_headers, sb.n_payload, sb.n_status);
        if (sb.mismatches == 0) begin
            $display("tb_capture_file_record_deframer: PASS");
        end else begin
            $display("tb_capture_file_record_deframer: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
